FILE: rtl/core/sequential_list_engine_assert.svh
// Assertion macros for the sequential list engine.
// Included by the top level; no other dependencies.
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequential_list_engine: assertion failed");

// Next-cycle implication, held off during reset.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequential_list_engine: assertion failed");

`endif

FILE: rtl/core/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// No dependencies; imported by the sequencer and the top level.
package sle_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_FIND   = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(4);

    localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        found_position;
        logic [LEN_W-1:0]        list_length;
        logic                    list_empty;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_FIND,
        S_SHIFT,
        S_RESP
    } t_state;

endpackage

FILE: rtl/core/sle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sle_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/sle_seq.sv
// Command sequencer: decodes a request, walks the element RAM, keeps the length.
// Depends on sle_pkg; drives one sle_ram instance owned by the top level.
module sle_seq
    import sle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_take,
    output t_rsp             o_rsp,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [VAL_W-1:0] i_rd_data,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [VAL_W-1:0] o_wr_data
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_pipe_vld, n_pipe_vld;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_moves, n_moves;
    logic [AW-1:0]       r_pipe_idx, n_pipe_idx;
    logic [AW-1:0]       r_ins_addr, n_ins_addr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]    r_read, n_read;
    logic [LEN_W-1:0]    r_found, n_found;

    logic            req_fire;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            bad_pos;
    logic            bad_ins;
    logic            is_full;
    logic            find_hit;
    logic            scan_more;
    logic            shift_end;
    logic            is_insert;

    // Decisions shared by the next-state and output blocks
    always_comb begin
        req_fire  = i_req_valid && (r_state == S_IDLE);
        pos_x     = CMPW'(i_req.position);
        cnt_x     = CMPW'(r_count);
        bad_pos   = (i_req.position == '0) || (pos_x > cnt_x);
        bad_ins   = (i_req.position == '0) || (pos_x > (cnt_x + CMPW'(1)));
        is_full   = (r_count >= CNT_FULL);
        find_hit  = r_pipe_vld && (i_rd_data == r_val);
        scan_more = (r_idx < r_count);
        shift_end = (r_moves == '0) && !r_pipe_vld;
        is_insert = (r_cmd == CMD_INSERT);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    unique case (i_req.command)
                        CMD_READ:   n_state = bad_pos ? S_RESP : S_RDWAIT;
                        CMD_FIND:   n_state = S_FIND;
                        CMD_INSERT: n_state = (bad_ins || is_full) ? S_RESP : S_SHIFT;
                        CMD_DELETE: n_state = bad_pos ? S_RESP : S_SHIFT;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_RESP;
            S_FIND: begin
                if (find_hit || !scan_more) begin
                    n_state = S_RESP;
                end
            end
            S_SHIFT: begin
                if (shift_end) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_pipe_vld = r_pipe_vld;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_idx      = r_idx;
        n_moves    = r_moves;
        n_pipe_idx = r_pipe_idx;
        n_ins_addr = r_ins_addr;
        n_status   = r_status;
        n_read     = r_read;
        n_found    = r_found;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_data  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_cmd      = i_req.command;
                    n_val      = i_req.item_value;
                    n_ins_addr = AW'(pos_x - CMPW'(1));
                    n_status   = ST_OK;
                    n_read     = '0;
                    n_found    = '0;
                    n_pipe_vld = 1'b0;
                    n_idx      = '0;
                    n_moves    = '0;
                    unique case (i_req.command)
                        CMD_CLEAR: n_count = '0;
                        CMD_READ: begin
                            if (bad_pos) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(pos_x - CMPW'(1));
                            end
                        end
                        CMD_INSERT: begin
                            if (bad_ins) begin
                                n_status = ST_RANGE;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                // move count-pos+1 elements up, top one first
                                n_moves = CW'(cnt_x - pos_x + CMPW'(1));
                                n_idx   = r_count - CW'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (bad_pos) begin
                                n_status = ST_RANGE;
                            end else begin
                                // move count-pos elements down, lowest first
                                n_moves = CW'(cnt_x - pos_x);
                                n_idx   = CW'(pos_x);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: n_read = i_rd_data;
            S_FIND: begin
                if (find_hit) begin
                    n_found = LEN_W'(CW'(r_pipe_idx) + CW'(1));
                end else if (scan_more) begin
                    o_rd_en    = 1'b1;
                    o_rd_addr  = r_idx[AW-1:0];
                    n_pipe_vld = 1'b1;
                    n_pipe_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_pipe_vld = 1'b0;
                end
            end
            S_SHIFT: begin
                // write back the element read last cycle one slot over
                if (r_pipe_vld) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = is_insert ? (r_pipe_idx + AW'(1)) : (r_pipe_idx - AW'(1));
                    o_wr_data = i_rd_data;
                end
                if (r_moves != '0) begin
                    o_rd_en    = 1'b1;
                    o_rd_addr  = r_idx[AW-1:0];
                    n_pipe_vld = 1'b1;
                    n_pipe_idx = r_idx[AW-1:0];
                    n_idx      = is_insert ? (r_idx - CW'(1)) : (r_idx + CW'(1));
                    n_moves    = r_moves - CW'(1);
                end else begin
                    n_pipe_vld = 1'b0;
                end
                if (shift_end) begin
                    if (is_insert) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_ins_addr;
                        o_wr_data = r_val;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_RESP: ;
            default: ;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);

    always_comb begin
        o_rsp.status         = r_status;
        o_rsp.read_value     = r_read;
        o_rsp.found_position = r_found;
        o_rsp.list_length    = LEN_W'(r_count);
        o_rsp.list_empty     = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pipe_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pipe_vld <= n_pipe_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_moves    <= n_moves;
        r_pipe_idx <= n_pipe_idx;
        r_ins_addr <= n_ins_addr;
        r_status   <= n_status;
        r_read     <= n_read;
        r_found    <= n_found;
    end

endmodule

FILE: rtl/core/sequential_list_engine.sv
// Ordered list engine: up to CAPACITY signed 32-bit elements held in one RAM.
// Channels: request (i_req_valid/o_req_ready, i_req) and response
// (o_rsp_valid/i_rsp_ready, o_rsp), both valid/ready; one response per request.
// Commands: clear, read at a 1-based position, find the first match, insert at
// a position, delete at a position. Bad positions and a full list give an error
// status and leave the list untouched.
// Work per request, N being the current length: clear, unknown commands and
//   rejected requests go straight to the response; read waits for one RAM read;
//   find: one RAM read per element, stops at the first match; insert moves
//   N-pos+1 elements up and delete N-pos elements down, and no element moves
//   for an insert at N+1 or a delete at N.
// One request is worked on at a time. The sequencer takes the next request in
// the cycle after it hands its response to the output register, so a new request
// is not taken until the walk through the element RAM, one read and one write
// per cycle, is done and its response handed on.
// The response sits in an output register, so the next request is taken while
// an earlier response waits; a stalled receiver only holds the sequencer once it
// has a second response ready.
// Reset (synchronous, active low) empties the list at once; element RAM
// contents are never cleared, since only entries below the length are read.
`include "sequential_list_engine_assert.svh"

module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);

    // sequencer to output stage
    logic seq_rsp_valid;
    logic seq_rsp_take;
    t_rsp seq_rsp;

    // element RAM port
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [VAL_W-1:0] ram_rd_data;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [VAL_W-1:0] ram_wr_data;

    // output register
    logic r_out_vld, n_out_vld;
    t_rsp r_out, n_out;

    // full-list rejection on the response port
    logic rsp_full;

    sle_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (seq_rsp_valid),
        .i_rsp_take  (seq_rsp_take),
        .o_rsp       (seq_rsp),
        .o_rd_en     (ram_rd_en),
        .o_rd_addr   (ram_rd_addr),
        .i_rd_data   (ram_rd_data),
        .o_wr_en     (ram_wr_en),
        .o_wr_addr   (ram_wr_addr),
        .o_wr_data   (ram_wr_data)
    );

    sle_ram #(
        .WIDTH  (VAL_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Load a finished response when the output register is free or draining
    assign seq_rsp_take = seq_rsp_valid && (!r_out_vld || i_rsp_ready);

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (seq_rsp_take) begin
            n_out_vld = 1'b1;
            n_out     = seq_rsp;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    assign rsp_full = o_rsp_valid && (o_rsp.status == ST_FULL);

    // A full-list rejection always reports a length at capacity
    `SLE_ASSERT_IMPL(a_full_at_capacity, i_clk, i_rst_n, rsp_full, o_rsp.list_length == LEN_FULL)
    // No RAM write once the sequencer has its response ready
    `SLE_ASSERT_IMPL(a_no_write_in_resp, i_clk, i_rst_n, seq_rsp_valid, !ram_wr_en)
    // Accepting a request makes the sequencer busy
    `SLE_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready)

endmodule
